// File: design/pau_pkg.sv
// ----------------------------------------------------------------------------
// pau_pkg
// shared constants, request codes, controller states and result record
// ----------------------------------------------------------------------------
package pau_pkg;

  localparam int unsigned Depth  = 32;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CoefW  = 32;

  typedef enum logic [2:0] {
    REQ_CLEAR = 3'd0,
    REQ_LOAD_A = 3'd1,
    REQ_LOAD_B = 3'd2,
    REQ_ADD = 3'd3,
    REQ_SUB = 3'd4,
    REQ_MUL = 3'd5,
    REQ_EVAL = 3'd6,
    REQ_READ = 3'd7
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_AS_RD,
    ST_AS_WR,
    ST_MU_RD,
    ST_MU_MUL,
    ST_MU_WR,
    ST_EV_RD,
    ST_EV_MUL,
    ST_EV_ACC,
    ST_RD_RD,
    ST_RD_EMIT,
    ST_ACK
  } state_e;

  typedef struct packed {
    logic [31:0] coef;
    logic [4:0]  exp;
    logic        present;
    logic [31:0] value;
    logic        status;
    logic        last;
  } pau_res_t;

endpackage

// File: design/pau_ram.sv
// ----------------------------------------------------------------------------
// pau_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module pau_ram #(
  parameter int unsigned DW = 32,
  parameter int unsigned AW = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/pau_out_reg.sv
// ----------------------------------------------------------------------------
// pau_out_reg
// result register between the controller and the output channel
// ----------------------------------------------------------------------------
module pau_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pau_pkg::pau_res_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [31:0] out_coef_o,
  output logic [4:0]        out_exp_o,
  output logic              term_present_o,
  output logic signed [31:0] eval_value_o,
  output logic              status_o,
  output logic              last_o
);
  import pau_pkg::*;

  logic     valid_q;
  pau_res_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && push_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_coef_o     = res_q.coef;
  assign out_exp_o      = res_q.exp;
  assign term_present_o = res_q.present;
  assign eval_value_o   = res_q.value;
  assign status_o       = res_q.status;
  assign last_o         = res_q.last;

endmodule

// File: design/polynomial_arith_unit.sv
// One request is worked at a time. A read-out of a non-empty A emits one result
// per present term, skipping absent exponents; every other request gives one result.
// Multiply walks all exponent pairs through the A, B and scratch ram read ports
// and adds a multiply and a write step for each pair of present terms whose
// exponent sum stays in range.
// Reset empties both polynomials at once through the presence bits.
// ----------------------------------------------------------------------------
// polynomial_arith_unit
// polynomial store with clear, load, add, subtract, multiply, evaluate and read-out
// ----------------------------------------------------------------------------
module polynomial_arith_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] term_coef_i,
  input  logic [4:0]         term_exp_i,
  input  logic signed [31:0] eval_point_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_coef_o,
  output logic [4:0]         out_exp_o,
  output logic               term_present_o,
  output logic signed [31:0] eval_value_o,
  output logic               status_o,
  output logic               last_o
);
  import pau_pkg::*;

  state_e             state_q, state_d;
  req_e               type_q;
  logic [CoefW-1:0]   coef_q, x_q, pw_q, prod_q, sacc_q, val_q;
  logic [AddrW-1:0]   exp_q, i_q, j_q, last_q;
  logic               status_q, sel_q;
  logic [Depth-1:0]   used_q [2];
  logic [Depth-1:0]   used_b_q;

  logic [Depth-1:0]   ua, us;
  logic [AddrW:0]     k6;
  logic [AddrW-1:0]   k;
  logic               accept, out_free, push, pair, mu_done;
  logic [AddrW-1:0]   enc_last;
  logic [AddrW-1:0]   ra_addr, rb_addr, rs_addr, wr_addr;
  logic               a_we, b_we, s_we;
  logic [CoefW-1:0]   wr_data, rd0, rd1, rdb, ra, rs;
  pau_res_t           res;

  assign accept  = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);
  assign ua      = used_q[sel_q];
  assign us      = used_q[!sel_q];
  assign k6      = {1'b0, i_q} + {1'b0, j_q};
  assign k       = k6[AddrW-1:0];
  assign pair    = ua[i_q] && used_b_q[j_q];
  assign mu_done = (i_q == AddrW'(Depth - 1)) && (j_q == AddrW'(Depth - 1));
  assign ra      = sel_q ? rd1 : rd0;
  assign rs      = sel_q ? rd0 : rd1;

  always_comb begin
    enc_last = '0;
    for (int d = 0; d < Depth; d++) begin
      if (ua[d]) begin
        enc_last = AddrW'(d);
      end
    end
  end

  pau_ram #(.DW(CoefW), .AW(AddrW)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (sel_q ? s_we : a_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (sel_q ? rs_addr : ra_addr),
    .rdata_o (rd0)
  );

  pau_ram #(.DW(CoefW), .AW(AddrW)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (sel_q ? a_we : s_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (sel_q ? ra_addr : rs_addr),
    .rdata_o (rd1)
  );

  pau_ram #(.DW(CoefW), .AW(AddrW)) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rb_addr),
    .rdata_o (rdb)
  );

  pau_out_reg u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .res_i          (res),
    .free_o         (out_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_coef_o     (out_coef_o),
    .out_exp_o      (out_exp_o),
    .term_present_o (term_present_o),
    .eval_value_o   (eval_value_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_e'(req_type_i))
            REQ_CLEAR:  state_d = ST_ACK;
            REQ_LOAD_A: state_d = ST_LD_RD;
            REQ_LOAD_B: state_d = ST_LD_RD;
            REQ_ADD:    state_d = ST_AS_RD;
            REQ_SUB:    state_d = ST_AS_RD;
            REQ_MUL:    state_d = ST_MU_RD;
            REQ_EVAL:   state_d = ST_EV_RD;
            REQ_READ:   state_d = (|ua) ? ST_RD_RD : ST_ACK;
            default:    state_d = ST_ACK;
          endcase
        end
      end
      ST_LD_RD:  state_d = ST_LD_WR;
      ST_LD_WR:  state_d = ST_ACK;
      ST_AS_RD:  state_d = ST_AS_WR;
      ST_AS_WR:  state_d = (i_q == AddrW'(Depth - 1)) ? ST_ACK : ST_AS_RD;
      ST_MU_RD: begin
        if (pair && !k6[AddrW]) begin
          state_d = ST_MU_MUL;
        end else if (mu_done) begin
          state_d = ST_ACK;
        end
      end
      ST_MU_MUL: state_d = ST_MU_WR;
      ST_MU_WR:  state_d = mu_done ? ST_ACK : ST_MU_RD;
      ST_EV_RD:  state_d = ST_EV_MUL;
      ST_EV_MUL: state_d = ST_EV_ACC;
      ST_EV_ACC: state_d = (i_q == AddrW'(Depth - 1)) ? ST_ACK : ST_EV_RD;
      ST_RD_RD:  state_d = ua[i_q] ? ST_RD_EMIT : ST_RD_RD;
      ST_RD_EMIT: begin
        if (out_free) begin
          state_d = (i_q == last_q) ? ST_IDLE : ST_RD_RD;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    ra_addr = i_q;
    rb_addr = j_q;
    rs_addr = k;
    wr_addr = i_q;
    wr_data = '0;
    a_we    = 1'b0;
    b_we    = 1'b0;
    s_we    = 1'b0;
    push    = 1'b0;
    res     = '0;
    case (state_q)
      ST_LD_RD: begin
        ra_addr = exp_q;
        rb_addr = exp_q;
      end
      ST_LD_WR: begin
        wr_addr = exp_q;
        if (type_q == REQ_LOAD_A) begin
          a_we    = 1'b1;
          wr_data = (ua[exp_q] ? ra : '0) + coef_q;
        end else begin
          b_we    = 1'b1;
          wr_data = (used_b_q[exp_q] ? rdb : '0) + coef_q;
        end
      end
      ST_AS_RD: rb_addr = i_q;
      ST_AS_WR: begin
        a_we    = used_b_q[i_q];
        wr_data = (type_q == REQ_ADD) ? (ua[i_q] ? ra : '0) + rdb
                                      : (ua[i_q] ? ra : '0) - rdb;
      end
      ST_MU_WR: begin
        s_we    = 1'b1;
        wr_addr = k;
        wr_data = sacc_q + prod_q;
      end
      ST_RD_EMIT: begin
        push        = out_free;
        res.coef    = 32'(ra);
        res.exp     = 5'(i_q);
        res.present = 1'b1;
        res.last    = (i_q == last_q);
      end
      ST_ACK: begin
        push       = out_free;
        res.value  = 32'(val_q);
        res.status = status_q;
        res.last   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      type_q    <= REQ_CLEAR;
      coef_q    <= '0;
      x_q       <= '0;
      pw_q      <= '0;
      prod_q    <= '0;
      sacc_q    <= '0;
      val_q     <= '0;
      exp_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      last_q    <= '0;
      status_q  <= 1'b0;
      sel_q     <= 1'b0;
      used_q[0] <= '0;
      used_q[1] <= '0;
      used_b_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            type_q   <= req_e'(req_type_i);
            coef_q   <= CoefW'(term_coef_i);
            exp_q    <= term_exp_i;
            x_q      <= CoefW'(eval_point_i);
            pw_q     <= CoefW'(1);
            val_q    <= '0;
            status_q <= 1'b0;
            i_q      <= '0;
            j_q      <= '0;
            last_q   <= enc_last;
            case (req_e'(req_type_i))
              REQ_CLEAR: begin
                used_q[0] <= '0;
                used_q[1] <= '0;
                used_b_q  <= '0;
              end
              REQ_MUL: used_q[!sel_q] <= '0;
              default: ;
            endcase
          end
        end
        ST_LD_WR: begin
          if (type_q == REQ_LOAD_A) begin
            used_q[sel_q][exp_q] <= 1'b1;
          end else begin
            used_b_q[exp_q] <= 1'b1;
          end
        end
        ST_AS_WR: begin
          if (used_b_q[i_q]) begin
            used_q[sel_q][i_q] <= 1'b1;
          end
          i_q <= i_q + 1'b1;
        end
        ST_MU_RD: begin
          if (pair && k6[AddrW]) begin
            status_q <= 1'b1;
          end
          if (!(pair && !k6[AddrW])) begin
            j_q <= j_q + 1'b1;
            if (j_q == AddrW'(Depth - 1)) begin
              i_q <= i_q + 1'b1;
            end
            if (mu_done) begin
              sel_q <= !sel_q;
            end
          end
        end
        ST_MU_MUL: begin
          prod_q <= CoefW'(ra * rdb);
          sacc_q <= us[k] ? rs : '0;
        end
        ST_MU_WR: begin
          used_q[!sel_q][k] <= 1'b1;
          j_q <= j_q + 1'b1;
          if (j_q == AddrW'(Depth - 1)) begin
            i_q <= i_q + 1'b1;
          end
          if (mu_done) begin
            sel_q <= !sel_q;
          end
        end
        ST_EV_MUL: begin
          prod_q <= CoefW'((ua[i_q] ? ra : '0) * pw_q);
          pw_q   <= CoefW'(pw_q * x_q);
        end
        ST_EV_ACC: begin
          val_q <= val_q + prod_q;
          i_q   <= i_q + 1'b1;
        end
        ST_RD_RD: begin
          if (!ua[i_q]) begin
            i_q <= i_q + 1'b1;
          end
        end
        ST_RD_EMIT: begin
          if (out_free) begin
            i_q <= i_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: tb/polynomial_arith_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polynomial_arith_unit_tb
// Drives directed and random requests into the polynomial unit. Each request
// is predicted by a local model of the A, B and product stores. Every result
// is checked field by field against the queue of predicted results.
// ----------------------------------------------------------------------------
module polynomial_arith_unit_tb;
  import pau_pkg::*;

  typedef struct {
    logic [31:0] coef;
    logic [4:0]  exp;
    logic        present;
    logic [31:0] value;
    logic        status;
    logic        last;
  } term_res_t;

  typedef struct {
    req_e        req;
    logic [31:0] coef;
    logic [4:0]  exp;
    logic [31:0] point;
    bit          known;
    logic [31:0] value;
  } row_t;

  localparam int unsigned WatchLimit = 20000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [2:0]        req_type_i = REQ_CLEAR;
  logic signed [31:0] term_coef_i = '0;
  logic [4:0]        term_exp_i = '0;
  logic signed [31:0] eval_point_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic signed [31:0] out_coef_o;
  logic [4:0]        out_exp_o;
  logic              term_present_o;
  logic signed [31:0] eval_value_o;
  logic              status_o;
  logic              last_o;

  logic [31:0] poly_a [Depth];
  bit          has_a [Depth];
  logic [31:0] poly_b [Depth];
  bit          has_b [Depth];
  term_res_t   pending_q [$];
  int          errors = 0;
  int          n_req = 0;
  int          n_res = 0;
  int          n_drop = 0;
  int          idle_cnt = 0;
  bit          calm = 1'b0;
  bit          sent_done = 1'b0;

  polynomial_arith_unit u_dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic term_res_t mk(logic [31:0] c, logic [4:0] e, logic p,
                                   logic [31:0] v, logic s, logic l);
    term_res_t r;
    r.coef = c; r.exp = e; r.present = p; r.value = v; r.status = s; r.last = l;
    return r;
  endfunction

  task automatic predict_poly(req_e req, logic [31:0] c, logic [4:0] e,
                              logic [31:0] x);
    logic [31:0] prod [Depth];
    bit          hp [Depth];
    logic [31:0] sum, pw;
    logic        st;
    int          top;
    st = 1'b0;
    case (req)
      REQ_CLEAR: begin
        for (int i = 0; i < Depth; i++) begin
          poly_a[i] = '0; has_a[i] = 0; poly_b[i] = '0; has_b[i] = 0;
        end
      end
      REQ_LOAD_A: begin
        poly_a[e] = poly_a[e] + c; has_a[e] = 1;
      end
      REQ_LOAD_B: begin
        poly_b[e] = poly_b[e] + c; has_b[e] = 1;
      end
      REQ_ADD, REQ_SUB: begin
        for (int i = 0; i < Depth; i++) if (has_b[i]) begin
          poly_a[i] = (req == REQ_ADD) ? poly_a[i] + poly_b[i] : poly_a[i] - poly_b[i];
          has_a[i] = 1;
        end
      end
      REQ_MUL: begin
        for (int i = 0; i < Depth; i++) begin prod[i] = '0; hp[i] = 0; end
        for (int i = 0; i < Depth; i++) if (has_a[i])
          for (int j = 0; j < Depth; j++) if (has_b[j]) begin
            if (i + j >= Depth) st = 1'b1;
            else begin
              prod[i+j] = prod[i+j] + poly_a[i] * poly_b[j]; hp[i+j] = 1;
            end
          end
        for (int i = 0; i < Depth; i++) begin poly_a[i] = prod[i]; has_a[i] = hp[i]; end
        if (st) n_drop++;
      end
      REQ_EVAL: begin
        sum = '0; pw = 32'd1;
        for (int i = 0; i < Depth; i++) begin
          if (has_a[i]) sum = sum + poly_a[i] * pw;
          pw = pw * x;
        end
        pending_q.push_back(mk('0, '0, 1'b0, sum, 1'b0, 1'b1));
        return;
      end
      default: begin
        top = -1;
        for (int i = 0; i < Depth; i++) if (has_a[i]) top = i;
        if (top < 0) pending_q.push_back(mk('0, '0, 1'b0, '0, 1'b0, 1'b1));
        for (int i = 0; i <= top; i++) if (has_a[i])
          pending_q.push_back(mk(poly_a[i], i[4:0], 1'b1, '0, 1'b0, i == top));
        return;
      end
    endcase
    pending_q.push_back(mk('0, '0, 1'b0, '0, st, 1'b1));
  endtask

  task automatic send_req(req_e req, logic [31:0] c, logic [4:0] e,
                          logic [31:0] x);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1; req_type_i <= req; term_coef_i <= c;
    term_exp_i <= e; eval_point_i <= x;
    predict_poly(req, c, e, x);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_req++;
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic random_coef(output logic [31:0] c);
    case ($urandom_range(3))
      0: c = $urandom;
      1: c = $urandom_range(7) - 3;
      2: c = {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: c = $urandom_range(100);
    endcase
  endtask

  // random requests, weighted toward low exponents so polynomials stay small
  task automatic random_req();
    logic [31:0] c, x;
    logic [4:0]  e;
    req_e        r;
    int          k;
    random_coef(c);
    random_coef(x);
    e = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(5));
    k = $urandom_range(99);
    if (k < 3)       r = REQ_CLEAR;
    else if (k < 35) r = REQ_LOAD_A;
    else if (k < 62) r = REQ_LOAD_B;
    else if (k < 68) r = REQ_ADD;
    else if (k < 74) r = REQ_SUB;
    else if (k < 80) r = REQ_MUL;
    else if (k < 90) r = REQ_EVAL;
    else             r = REQ_READ;
    send_req(r, c, e, x);
  endtask

  row_t rows [] = '{
    '{REQ_READ,   32'h0, 5'd0, 32'h0, 1, 32'h0},
    '{REQ_EVAL,   32'h0, 5'd0, 32'h0, 1, 32'h0},
    '{REQ_LOAD_A, 32'h7fff_ffff, 5'd0, 32'h0, 0, 32'h0},
    '{REQ_LOAD_A, 32'h0000_0001, 5'd0, 32'h0, 0, 32'h0},
    '{REQ_LOAD_A, 32'h8000_0000, 5'd31, 32'h0, 0, 32'h0},
    '{REQ_LOAD_A, 32'h0, 5'd7, 32'h0, 0, 32'h0},
    '{REQ_READ,   32'h0, 5'd0, 32'h0, 0, 32'h0},
    '{REQ_EVAL,   32'h0, 5'd0, 32'h0, 0, 32'h0},
    '{REQ_EVAL,   32'h0, 5'd0, 32'hffff_ffff, 0, 32'h0},
    '{REQ_LOAD_B, 32'hffff_ffff, 5'd31, 32'h0, 0, 32'h0},
    '{REQ_LOAD_B, 32'h0000_0003, 5'd1, 32'h0, 0, 32'h0},
    '{REQ_ADD,    32'h0, 5'd0, 32'h0, 0, 32'h0},
    '{REQ_SUB,    32'h0, 5'd0, 32'h0, 0, 32'h0},
    '{REQ_MUL,    32'h0, 5'd0, 32'h0, 0, 32'h0},
    '{REQ_READ,   32'h0, 5'd0, 32'h0, 0, 32'h0},
    '{REQ_EVAL,   32'h0, 5'd0, 32'h7fff_ffff, 0, 32'h0},
    '{REQ_CLEAR,  32'h0, 5'd0, 32'h0, 0, 32'h0},
    '{REQ_LOAD_B, 32'h5, 5'd2, 32'h0, 0, 32'h0},
    '{REQ_MUL,    32'h0, 5'd0, 32'h0, 0, 32'h0},
    '{REQ_READ,   32'h0, 5'd0, 32'h0, 1, 32'h0},
    '{REQ_LOAD_A, 32'h2, 5'd0, 32'h0, 0, 32'h0},
    '{REQ_EVAL,   32'h0, 5'd0, 32'h8000_0000, 1, 32'h2}
  };

  always @(negedge clk_i)
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 26);

  always @(posedge clk_i) begin
    if (rst_ni && ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  always @(posedge clk_i) begin
    term_res_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_res++;
      if (pending_q.size() == 0) begin
        $error("result with no request waiting");
        errors++;
      end else begin
        w = pending_q.pop_front();
        if (out_coef_o !== w.coef) begin
          $error("out_coef exp %h got %h", w.coef, out_coef_o); errors++;
        end
        if (out_exp_o !== w.exp) begin
          $error("out_exp exp %0d got %0d", w.exp, out_exp_o); errors++;
        end
        if (term_present_o !== w.present) begin
          $error("term_present exp %b got %b", w.present, term_present_o); errors++;
        end
        if (eval_value_o !== w.value) begin
          $error("eval_value exp %h got %h", w.value, eval_value_o); errors++;
        end
        if (status_o !== w.status) begin
          $error("status exp %b got %b", w.status, status_o); errors++;
        end
        if (last_o !== w.last) begin
          $error("last exp %b got %b", w.last, last_o); errors++;
        end
      end
    end
    if (idle_cnt > WatchLimit) begin
      $display("watchdog: no progress");
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    term_res_t chk;
    for (int i = 0; i < Depth; i++) begin
      poly_a[i] = '0; has_a[i] = 0; poly_b[i] = '0; has_b[i] = 0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) begin
      send_req(rows[i].req, rows[i].coef, rows[i].exp, rows[i].point);
      if (rows[i].known) begin
        chk = pending_q[pending_q.size()-1];
        if (chk.value !== rows[i].value) begin
          $error("eval_value table exp %h model %h", rows[i].value, chk.value);
          errors++;
        end
      end
    end
    wait_drain();
    for (int n = 0; n < 360; n++) begin
      calm = (n >= 150 && n < 200);
      if (n == 100) wait_drain();
      if (n % 60 == 59) send_req(REQ_CLEAR, '0, '0, '0);
      random_req();
    end
    calm = 1'b0;
    wait_drain();
    repeat (1100) @(negedge clk_i);
    $display("%0d requests, %0d results, %0d multiplies with dropped terms",
             n_req, n_res, n_drop);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
